[rtl/clamp_motion_sequencer_top_assert.svh]
// assertion macros for the clamp motion sequencer top level
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef CLAMP_MOTION_SEQUENCER_TOP_ASSERT_SVH
`define CLAMP_MOTION_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTH
`define CLMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clamp sequencer check failed");
`define CLMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clamp sequencer check failed");
`else
`define CLMS_ASSERT_NOW(lbl, ante, cons)
`define CLMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/clms_pkg.sv]
// types and constants shared by the clamp motion sequencer modules
// no dependencies
`timescale 1ns / 1ps

package clms_pkg;

  typedef enum logic [3:0] {
    ACT_TICK         = 4'd0,
    ACT_START_CLAMP  = 4'd1,
    ACT_START_COMP   = 4'd2,
    ACT_START_CLUTCH = 4'd3,
    ACT_EJECT_ON     = 4'd4,
    ACT_EJECT_OFF    = 4'd5,
    ACT_CLAMP_ON     = 4'd6,
    ACT_CLAMP_OFF    = 4'd7,
    ACT_STOP         = 4'd8,
    ACT_RESET        = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    CFG_UP_START    = 3'd0,
    CFG_UP_STOP     = 3'd1,
    CFG_LOWER_START = 3'd2,
    CFG_LOWER_STOP  = 3'd3,
    CFG_FAIL_TIME   = 3'd4
  } cfg_idx_e;

  localparam logic [3:0] STG_IDLE       = 4'd0;
  localparam logic [3:0] STG_EJECT_ON   = 4'd1;
  localparam logic [3:0] STG_EJECT_OFF  = 4'd2;
  localparam logic [3:0] STG_UP_START   = 4'd3;
  localparam logic [3:0] STG_CLAMP_OFF  = 4'd4;
  localparam logic [3:0] STG_UP_STOP    = 4'd5;
  localparam logic [3:0] STG_LOWER      = 4'd6;
  localparam logic [3:0] STG_CLAMP_ON   = 4'd7;
  localparam logic [3:0] STG_LOWER_STOP = 4'd8;
  localparam logic [3:0] STG_DONE       = 4'd9;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_CLAMP  = 2'd1;
  localparam logic [1:0] MODE_CLUTCH = 2'd2;

  localparam logic [1:0] DONE_CLAMP     = 2'd0;
  localparam logic [1:0] DONE_COMPONENT = 2'd1;
  localparam logic [1:0] DONE_STOPPED   = 2'd2;

  localparam logic FAIL_NEVER_OFF = 1'b0;
  localparam logic FAIL_NEVER_ON  = 1'b1;

  localparam logic [6:0]  SHEET_NONE      = 7'd64;
  localparam logic [15:0] FAIL_TIME_RESET = 16'd400;
  localparam logic [15:0] T6_UNIT         = 16'd10;

  typedef struct packed {
    logic [15:0] up_start_time;
    logic [7:0]  up_stop_time;
    logic [7:0]  lower_start_time;
    logic [7:0]  lower_stop_time;
    logic [15:0] fail_time;
  } cfg_t;

  typedef struct packed {
    logic [3:0] action;
    logic [6:0] sheet_no;
    logic       clamp_home_level;
    logic       sheet_condition_ok;
  } item_t;

  typedef struct packed {
    logic       clutch_on;
    logic       busy_res;
    logic       fault;
    logic       done_valid;
    logic [1:0] done_kind;
    logic [3:0] done_stage;
    logic [6:0] done_sheet;
    logic       fail_valid;
    logic       fail_kind;
  } res_t;

endpackage

[rtl/clamp_motion_sequencer_top.sv]
// top level of the clamp motion sequencer: input register, sequencer, result register
// depends on clms_pkg, clms_cfg, clms_seq and clamp_motion_sequencer_top_assert.svh
`timescale 1ns / 1ps

//  channel   direction  handshake               payload
//  in        slave      in_valid_i / in_stall_o action, sheet number, sensor level, condition
//  out       master     out_valid_o / out_stall_i clutch, busy, fault, done and fail reports
//  cfg       slave      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  one beat per cycle sustained while the output is not stalled; an accepted beat goes
//  through the input register, then one pass of sequencer logic into the result register
//  reset is asynchronous, active low; it clears sequencer state and loads register defaults
//  an output stall holds the result register and, once it is full, the input register;
//  configuration writes are always taken

`include "clamp_motion_sequencer_top_assert.svh"

module clamp_motion_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [6:0]  sheet_no_i,
  input  logic        clamp_home_level_i,
  input  logic        sheet_condition_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        clutch_on_o,
  output logic        busy_res_o,
  output logic        fault_o,
  output logic        done_valid_o,
  output logic [1:0]  done_kind_o,
  output logic [3:0]  done_stage_o,
  output logic [6:0]  done_sheet_o,
  output logic        fail_valid_o,
  output logic        fail_kind_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import clms_pkg::*;

  logic  in_valid_q;
  item_t item_q;
  logic  out_valid_q;
  res_t  res_q;
  res_t  res;
  cfg_t  cfg;
  logic  fire;
  logic  in_take;

  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  clms_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  clms_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action             <= action_i;
      item_q.sheet_no           <= sheet_no_i;
      item_q.clamp_home_level   <= clamp_home_level_i;
      item_q.sheet_condition_ok <= sheet_condition_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign clutch_on_o  = res_q.clutch_on;
  assign busy_res_o   = res_q.busy_res;
  assign fault_o      = res_q.fault;
  assign done_valid_o = res_q.done_valid;
  assign done_kind_o  = res_q.done_kind;
  assign done_stage_o = res_q.done_stage;
  assign done_sheet_o = res_q.done_sheet;
  assign fail_valid_o = res_q.fail_valid;
  assign fail_kind_o  = res_q.fail_kind;

  `CLMS_ASSERT_NEXT(a_fire_fills_out, fire, out_valid_q)
  `CLMS_ASSERT_NOW(a_fail_sets_fault, out_valid_q && res_q.fail_valid, res_q.fault)
  `CLMS_ASSERT_NOW(a_done_goes_idle, out_valid_q && res_q.done_valid && res_q.done_kind != DONE_STOPPED, !res_q.busy_res && !res_q.clutch_on && res_q.done_stage == STG_DONE)
  `CLMS_ASSERT_NOW(a_done_fail_apart, out_valid_q && res_q.done_valid, !res_q.fail_valid)

endmodule

[rtl/clms_cfg.sv]
// configuration register file for the clamp motion sequencer
// depends on clms_pkg
`timescale 1ns / 1ps

module clms_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  logic [2:0]      index_i,
  input  logic [15:0]     data_i,
  output clms_pkg::cfg_t  cfg_o
);
  import clms_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_start_time    <= '0;
      cfg_q.up_stop_time     <= '0;
      cfg_q.lower_start_time <= '0;
      cfg_q.lower_stop_time  <= '0;
      cfg_q.fail_time        <= FAIL_TIME_RESET;
    end else if (wr_i) begin
      case (cfg_idx_e'(index_i))
        CFG_UP_START:    cfg_q.up_start_time    <= data_i;
        CFG_UP_STOP:     cfg_q.up_stop_time     <= data_i[7:0];
        CFG_LOWER_START: cfg_q.lower_start_time <= data_i[7:0];
        CFG_LOWER_STOP:  cfg_q.lower_stop_time  <= data_i[7:0];
        CFG_FAIL_TIME:   cfg_q.fail_time        <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/clms_seq.sv]
// sequencer state and single-pass next-state logic for one beat
// depends on clms_pkg
`timescale 1ns / 1ps

module clms_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  clms_pkg::item_t item_i,
  input  clms_pkg::cfg_t  cfg_i,
  output clms_pkg::res_t  res_o
);
  import clms_pkg::*;

  logic [3:0]  stage_q, stage_d, enter_stage;
  logic [1:0]  mode_q, mode_d;
  logic [6:0]  sheet_q, sheet_d;
  logic        run_q, run_d;
  logic [15:0] rem_q, rem_d;
  logic        clutch_q, clutch_d;
  logic        fault_q, fault_d;
  logic        do_enter, do_stop;
  res_t        res;

  always_comb begin
    stage_d     = stage_q;
    mode_d      = mode_q;
    sheet_d     = sheet_q;
    run_d       = run_q;
    rem_d       = rem_q;
    clutch_d    = clutch_q;
    fault_d     = fault_q;
    do_enter    = 1'b0;
    do_stop     = 1'b0;
    enter_stage = STG_IDLE;
    res         = '0;

    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (run_q) begin
          if (rem_q <= 16'd1) begin
            run_d = 1'b0;
            rem_d = '0;
            case (stage_q)
              STG_EJECT_ON, STG_UP_START, STG_UP_STOP, STG_LOWER, STG_LOWER_STOP: begin
                stage_d  = stage_q + 4'd1;
                do_enter = 1'b1;
              end
              STG_CLAMP_OFF: begin
                fault_d        = 1'b1;
                res.fail_valid = 1'b1;
                res.fail_kind  = FAIL_NEVER_OFF;
              end
              STG_CLAMP_ON: begin
                fault_d        = 1'b1;
                res.fail_valid = 1'b1;
                res.fail_kind  = FAIL_NEVER_ON;
              end
              default: ;
            endcase
          end else begin
            rem_d = rem_q - 16'd1;
          end
        end
      end
      ACT_START_CLAMP, ACT_START_COMP, ACT_START_CLUTCH: begin
        if (action_e'(item_i.action) == ACT_START_CLUTCH) begin
          mode_d   = MODE_CLUTCH;
          clutch_d = 1'b1;
        end else begin
          stage_d = STG_EJECT_ON;
          if (action_e'(item_i.action) == ACT_START_COMP) begin
            mode_d = MODE_CLAMP;
          end
        end
        sheet_d  = item_i.sheet_no;
        run_d    = 1'b0;
        rem_d    = '0;
        do_enter = 1'b1;
      end
      ACT_EJECT_ON: begin
        if (stage_q == STG_EJECT_ON) begin
          run_d   = 1'b0;
          rem_d   = '0;
          stage_d = STG_EJECT_OFF;
        end
      end
      ACT_EJECT_OFF: begin
        if (stage_q == STG_EJECT_OFF) begin
          run_d    = 1'b0;
          rem_d    = '0;
          stage_d  = STG_UP_START;
          do_enter = 1'b1;
        end
      end
      ACT_CLAMP_ON: begin
        if (stage_q == STG_CLAMP_ON) begin
          run_d    = 1'b0;
          rem_d    = '0;
          stage_d  = STG_LOWER_STOP;
          do_enter = 1'b1;
        end
      end
      ACT_CLAMP_OFF: begin
        if (stage_q == STG_CLAMP_OFF) begin
          run_d    = 1'b0;
          rem_d    = '0;
          stage_d  = STG_UP_STOP;
          do_enter = 1'b1;
        end
      end
      ACT_STOP: begin
        if (item_i.sheet_no == SHEET_NONE) begin
          do_stop = (sheet_q != SHEET_NONE) && !item_i.sheet_condition_ok;
        end else begin
          do_stop = (item_i.sheet_no == sheet_q);
        end
      end
      ACT_RESET: begin
        stage_d = STG_IDLE;
        mode_d  = MODE_NONE;
        sheet_d = SHEET_NONE;
        run_d   = 1'b0;
        rem_d   = '0;
        fault_d = 1'b0;
      end
      default: ;
    endcase

    // early stop, reported only while mode_q is MODE_NONE (not in component or clutch mode)
    if (do_stop) begin
      if (mode_q == MODE_NONE) begin
        res.done_valid = 1'b1;
        res.done_kind  = DONE_STOPPED;
        res.done_stage = stage_q;
        res.done_sheet = sheet_q;
      end
      stage_d  = STG_IDLE;
      sheet_d  = SHEET_NONE;
      run_d    = 1'b0;
      rem_d    = '0;
      clutch_d = 1'b0;
      mode_d   = MODE_NONE;
    end

    // stage entry actions
    if (do_enter) begin
      enter_stage = stage_d;
      case (enter_stage)
        STG_EJECT_ON: begin
          run_d = 1'b1;
          rem_d = '0;
        end
        STG_UP_START: begin
          run_d = 1'b1;
          rem_d = cfg_i.up_start_time;
        end
        STG_CLAMP_OFF: begin
          run_d = 1'b1;
          if (!item_i.clamp_home_level) begin
            stage_d = STG_UP_STOP;
            rem_d   = {8'd0, cfg_i.up_stop_time};
          end else begin
            clutch_d = 1'b1;
            rem_d    = cfg_i.fail_time;
          end
        end
        STG_UP_STOP: begin
          run_d = 1'b1;
          rem_d = {8'd0, cfg_i.up_stop_time};
        end
        STG_LOWER: begin
          clutch_d = 1'b0;
          run_d    = 1'b1;
          rem_d    = {8'd0, cfg_i.lower_start_time} * T6_UNIT;
        end
        STG_CLAMP_ON: begin
          clutch_d = 1'b1;
          run_d    = 1'b1;
          rem_d    = cfg_i.fail_time;
        end
        STG_LOWER_STOP: begin
          run_d = 1'b1;
          rem_d = {8'd0, cfg_i.lower_stop_time};
        end
        STG_DONE: begin
          clutch_d       = 1'b0;
          res.done_valid = 1'b1;
          res.done_kind  = (mode_d != MODE_NONE) ? DONE_COMPONENT : DONE_CLAMP;
          res.done_stage = STG_DONE;
          res.done_sheet = sheet_d;
          mode_d         = MODE_NONE;
          stage_d        = STG_IDLE;
        end
        default: ;
      endcase
    end

    res.clutch_on = clutch_d;
    res.busy_res  = (stage_d != STG_IDLE);
    res.fault     = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= STG_IDLE;
      mode_q   <= MODE_NONE;
      sheet_q  <= SHEET_NONE;
      run_q    <= 1'b0;
      rem_q    <= '0;
      clutch_q <= 1'b0;
      fault_q  <= 1'b0;
    end else if (fire_i) begin
      stage_q  <= stage_d;
      mode_q   <= mode_d;
      sheet_q  <= sheet_d;
      run_q    <= run_d;
      rem_q    <= rem_d;
      clutch_q <= clutch_d;
      fault_q  <= fault_d;
    end
  end

  assign res_o = res;

endmodule
